### hw/rtl/keyed_sequential_list_core_defines.svh
// Assertion macros for the keyed sequential list core
`ifndef KEYED_SEQUENTIAL_LIST_CORE_DEFINES_SVH
`define KEYED_SEQUENTIAL_LIST_CORE_DEFINES_SVH

// Plain property, checked on every clock outside reset
`define KSLC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Overlapping implication, checked outside reset
`define KSLC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define KSLC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/kslc_pkg.sv
// Shared types and constants of the keyed sequential list core
`default_nettype none
package kslc_pkg;

    localparam int DEPTH  = 64;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int OP_W   = 2;
    localparam int KEY_W  = 31;
    localparam int AMT_W  = 32;
    localparam int TOT_W  = 44;
    localparam int STAT_W = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [KEY_W-1:0] key;
        logic [AMT_W-1:0] amount;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [KEY_W-1:0]  record_key;
        logic [AMT_W-1:0]  record_amount;
        logic [TOT_W-1:0]  total_amount;
        logic [AMT_W-1:0]  mean_amount;
        logic [CNT_W-1:0]  entry_total;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic ins;
        logic del;
        logic rot;
        logic cmp;
    } t_cell_ctl;

endpackage
`default_nettype wire

### hw/rtl/kslc_cell.sv
// One record cell of the list chain: holds a key and an amount
`default_nettype none
module kslc_cell
    import kslc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic             i_wr_here,
    input  wire logic             i_wrap_here,
    input  wire logic             i_occ,
    input  wire logic [KEY_W-1:0] i_new_key,
    input  wire logic [AMT_W-1:0] i_new_amt,
    input  wire logic [KEY_W-1:0] i_nb_key,
    input  wire logic [AMT_W-1:0] i_nb_amt,
    input  wire logic [KEY_W-1:0] i_head_key,
    input  wire logic [AMT_W-1:0] i_head_amt,
    input  wire logic             i_seen,
    output logic      [KEY_W-1:0] o_key,
    output logic      [AMT_W-1:0] o_amt,
    output logic                  o_seen
);

    logic [KEY_W-1:0] r_key;
    logic [AMT_W-1:0] r_amt;
    logic             r_match;

    assign o_key  = r_key;
    assign o_amt  = r_amt;
    assign o_seen = i_seen | r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_match <= i_occ && (r_key == i_new_key);
        end
        if (i_ctl.ins && i_wr_here) begin
            r_key <= i_new_key;
            r_amt <= i_new_amt;
        end else if (i_ctl.del && o_seen) begin
            r_key <= i_nb_key;
            r_amt <= i_nb_amt;
        end else if (i_ctl.rot) begin
            if (i_wrap_here) begin
                r_key <= i_head_key;
                r_amt <= i_head_amt;
            end else begin
                r_key <= i_nb_key;
                r_amt <= i_nb_amt;
            end
        end
    end

endmodule
`default_nettype wire

### hw/rtl/kslc_div.sv
// Bit-serial restoring divider for the mean of the listed amounts
`default_nettype none
module kslc_div
    import kslc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [TOT_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [AMT_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(TOT_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_div;
    logic [CNT_W-1:0]  r_rem;
    logic [TOT_W-1:0]  r_quo;
    logic [CNT_W:0]    w_rem_sh;
    logic              w_ge;
    logic [CNT_W:0]    w_rem_sub;

    assign w_rem_sh   = {r_rem, r_quo[TOT_W-1]};
    assign w_ge       = (w_rem_sh >= {1'b0, r_div});
    assign w_rem_sub  = w_rem_sh - {1'b0, r_div};
    assign o_done     = r_done;
    assign o_quotient = r_quo[AMT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(TOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_rem_sub[CNT_W-1:0] : w_rem_sh[CNT_W-1:0];
            r_quo <= {r_quo[TOT_W-2:0], w_ge};
        end
    end

endmodule
`default_nettype wire

### hw/rtl/keyed_sequential_list_core.sv
// Top level of the keyed sequential list core: control, cell chain and divider
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------
//  input   | in        | i_valid / o_ready  | i_item (t_in_item)
//  result  | out       | o_valid / i_ready  | o_item (t_out_item)
//
// Insert and delete each take a capture step (with key compare for delete),
// then one chain step. List of N records rotates the cell chain by one record
// per result taken, then runs 44 divider steps before the last item.
// Synchronous active-low reset empties the list; cell contents are not cleared.
// A stalled result holds the controller in place; no item is taken until done.
`default_nettype none
`include "keyed_sequential_list_core_defines.svh"
module keyed_sequential_list_core
    import kslc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_item,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_item
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_LIST,
        S_DIV,
        S_LAST
    } t_state;

    t_state           r_state, n_state;
    logic             r_out_vld, n_out_vld;
    t_out_item        r_out, n_out;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [TOT_W-1:0] r_total, n_total;
    logic [KEY_W-1:0] r_key, n_key;
    logic [AMT_W-1:0] r_amt, n_amt;

    t_cell_ctl        w_ctl;
    logic             w_accept;
    logic             w_load;
    logic             w_div_start;
    logic             w_div_done;
    logic [AMT_W-1:0] w_quotient;
    logic [CNT_W-1:0] w_cnt_m1;
    logic             w_found;
    logic [KEY_W-1:0] w_cmp_key;

    logic [KEY_W-1:0] w_key  [DEPTH];
    logic [AMT_W-1:0] w_amt  [DEPTH];
    logic [DEPTH:0]   w_seen;

    assign o_ready   = (r_state == S_IDLE);
    assign w_accept  = i_valid && o_ready;
    assign o_valid   = r_out_vld;
    assign o_item    = r_out;
    assign w_load    = !r_out_vld || i_ready;
    assign w_cnt_m1  = r_count - CNT_W'(1);
    assign w_found   = w_seen[DEPTH];
    assign w_seen[0] = 1'b0;
    assign w_cmp_key = w_ctl.cmp ? i_item.key : r_key;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [KEY_W-1:0] w_nb_key;
        logic [AMT_W-1:0] w_nb_amt;

        if (g == DEPTH - 1) begin : g_tail
            assign w_nb_key = w_key[0];
            assign w_nb_amt = w_amt[0];
        end else begin : g_mid
            assign w_nb_key = w_key[g+1];
            assign w_nb_amt = w_amt[g+1];
        end

        kslc_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_wr_here  (r_count == CNT_W'(g)),
            .i_wrap_here(r_count == CNT_W'(g + 1)),
            .i_occ      (CNT_W'(g) < r_count),
            .i_new_key  (w_cmp_key),
            .i_new_amt  (r_amt),
            .i_nb_key   (w_nb_key),
            .i_nb_amt   (w_nb_amt),
            .i_head_key (w_key[0]),
            .i_head_amt (w_amt[0]),
            .i_seen     (w_seen[g]),
            .o_key      (w_key[g]),
            .o_amt      (w_amt[g]),
            .o_seen     (w_seen[g+1])
        );
    end

    kslc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_dividend(n_total),
        .i_divisor (r_count),
        .o_done    (w_div_done),
        .o_quotient(w_quotient)
    );

    always_comb begin
        n_state     = r_state;
        n_out_vld   = r_out_vld && !i_ready;
        n_out       = r_out;
        n_count     = r_count;
        n_idx       = r_idx;
        n_total     = r_total;
        n_key       = r_key;
        n_amt       = r_amt;
        w_ctl       = '0;
        w_div_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_key     = i_item.key;
                    n_amt     = i_item.amount;
                    n_idx     = '0;
                    n_total   = '0;
                    w_ctl.cmp = (i_item.operation == OP_DELETE);
                    unique case (i_item.operation)
                        OP_INSERT: n_state = S_INS;
                        OP_DELETE: n_state = S_DEL;
                        OP_LIST:   n_state = S_LIST;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_INS: begin
                if (w_load) begin
                    n_out = '0;
                    if (r_count == CNT_W'(DEPTH)) begin
                        n_out.status = ST_FULL;
                    end else begin
                        w_ctl.ins    = 1'b1;
                        n_count      = r_count + CNT_W'(1);
                        n_out.status = ST_OK;
                    end
                    n_out.entry_total = n_count;
                    n_out.last        = 1'b1;
                    n_out_vld         = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_DEL: begin
                if (w_load) begin
                    n_out = '0;
                    if (w_found) begin
                        w_ctl.del    = 1'b1;
                        n_count      = w_cnt_m1;
                        n_out.status = ST_OK;
                    end else begin
                        n_out.status = ST_NOT_FOUND;
                    end
                    n_out.entry_total = n_count;
                    n_out.last        = 1'b1;
                    n_out_vld         = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_LIST: begin
                if (r_count == '0) begin
                    if (w_load) begin
                        n_out        = '0;
                        n_out.status = ST_EMPTY;
                        n_out.last   = 1'b1;
                        n_out_vld    = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if ({1'b0, r_idx} == w_cnt_m1) begin
                    n_total     = r_total + TOT_W'(w_amt[0]);
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end else if (w_load) begin
                    n_out               = '0;
                    n_out.status        = ST_OK;
                    n_out.record_key    = w_key[0];
                    n_out.record_amount = w_amt[0];
                    n_out.entry_total   = r_count;
                    n_out_vld           = 1'b1;
                    n_total             = r_total + TOT_W'(w_amt[0]);
                    n_idx               = r_idx + IDX_W'(1);
                    w_ctl.rot           = 1'b1;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                if (w_load) begin
                    n_out.status        = ST_OK;
                    n_out.record_key    = w_key[0];
                    n_out.record_amount = w_amt[0];
                    n_out.total_amount  = r_total;
                    n_out.mean_amount   = w_quotient;
                    n_out.entry_total   = r_count;
                    n_out.last          = 1'b1;
                    n_out_vld           = 1'b1;
                    w_ctl.rot           = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_count   <= '0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_count   <= n_count;
            r_idx     <= n_idx;
        end
        r_out   <= n_out;
        r_total <= n_total;
        r_key   <= n_key;
        r_amt   <= n_amt;
    end

    `KSLC_ASSERT(a_count_bound, r_count <= CNT_W'(DEPTH), "entry count beyond depth")
    `KSLC_ASSERT_IMP(a_div_in_state, w_div_done, r_state == S_DIV, "divider done outside wait")
    `KSLC_ASSERT_IMP(a_idx_bound, (r_state == S_LIST) && (r_count != '0), ({1'b0, r_idx} < r_count), "list index past count")
    `KSLC_ASSERT_NXT(a_ins_grow, (r_state == S_INS) && w_load && (r_count != CNT_W'(DEPTH)), r_count == $past(r_count) + CNT_W'(1), "insert did not grow list")

endmodule
`default_nettype wire
